FILE: rtl/core/psr_pkg.sv
// Shared types and constants for the per-symbol true range block.
// No dependencies; imported by every module of the block.
package psr_pkg;

    localparam int DEFAULT_SYMBOL_SLOTS = 256;
    localparam int QUEUE_DEPTH          = 2;
    localparam int CFG_INDEX_W          = 2;
    localparam int CFG_DATA_W           = 63;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_TIME      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLED         = 2'd2;

    // result kinds
    localparam logic KIND_TRUE_RANGE = 1'b0;
    localparam logic KIND_PASS       = 1'b1;

    typedef struct packed {
        logic [7:0]         symbol_index;
        logic [62:0]        trade_timestamp;
        logic signed [31:0] trade_price;
    } trade_t;

    typedef struct packed {
        logic               result_kind;
        logic [7:0]         result_symbol;
        logic [62:0]        result_timestamp;
        logic signed [31:0] result_value;
    } result_t;

    // classified trade handed from front to back
    typedef struct packed {
        logic        pass;
        logic [7:0]  sym;
        logic [62:0] ts;
        logic [31:0] price;
        logic [62:0] bar;
    } job_t;

endpackage

FILE: rtl/core/psr_front.sv
// Front part: accepts trades, classifies them and computes the bar number
// with a one-bit-per-cycle restoring divider. Depends on psr_pkg.
module psr_front
    import psr_pkg::*;
#(
    parameter int SYMBOL_SLOTS = DEFAULT_SYMBOL_SLOTS
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        trade_valid,
    output logic        trade_ready,
    input  trade_t      trade,
    input  logic [31:0] interval_length,
    input  logic [62:0] start_time,
    input  logic        enabled,
    output logic        push_valid,
    input  logic        push_ready,
    output job_t        push_job
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t     state_reg, state_next;
    job_t        job_reg, job_next;
    logic [32:0] rem_reg, rem_next;
    logic [62:0] quo_reg, quo_next;
    logic [31:0] div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic [32:0] shifted;
    logic        ge;
    logic [16:0] slot_ext;
    logic        in_range;

    assign trade_ready = (state_reg == F_IDLE);
    assign push_valid  = (state_reg == F_PUSH);
    assign push_job    = job_reg;

    assign slot_ext = 17'(trade.symbol_index);
    assign in_range = slot_ext < 17'(SYMBOL_SLOTS);

    // one restoring division step
    assign shifted = {rem_reg[31:0], quo_reg[62]};
    assign ge      = shifted >= {1'b0, div_reg};

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (trade_valid)
                begin
                    job_next.sym   = trade.symbol_index;
                    job_next.ts    = trade.trade_timestamp;
                    job_next.price = trade.trade_price;
                    job_next.bar   = '0;
                    if (!enabled)
                    begin
                        job_next.pass = 1'b1;
                        state_next    = F_PUSH;
                    end
                    else if (in_range)
                    begin
                        // clamp timestamps before the origin to bar zero
                        job_next.pass = 1'b0;
                        quo_next = (trade.trade_timestamp > start_time) ?
                                   (trade.trade_timestamp - start_time) : '0;
                        rem_next = '0;
                        div_next = (interval_length == '0) ? 32'd1 : interval_length;
                        cnt_next = '0;
                        state_next = F_DIV;
                    end
                    // drop out-of-range slots: stay idle
                end
            end
            F_DIV:
            begin
                rem_next = ge ? (shifted - {1'b0, div_reg}) : shifted;
                quo_next = {quo_reg[61:0], ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd62)
                begin
                    job_next.bar = {quo_reg[61:0], ge};
                    state_next   = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
    end

endmodule

FILE: rtl/core/psr_queue.sv
// Short word queue between front and back parts.
// Depends on psr_pkg for the job word type.
module psr_queue
    import psr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop,
    output job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // store pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_job;
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/core/psr_back.sv
// Back part: per-symbol record read-modify-write, true range and output
// register. Depends on psr_pkg.
module psr_back
    import psr_pkg::*;
#(
    parameter int SYMBOL_SLOTS = DEFAULT_SYMBOL_SLOTS
)(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pop_valid,
    output logic    pop,
    input  job_t    pop_job,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int ADDR_W = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;

    typedef struct packed {
        logic [62:0] bar;
        logic [31:0] high;
        logic [31:0] low;
        logic [31:0] close;
        logic [31:0] prev;
    } rec_t;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_CALC = 2'b10
    } bstate_t;

    bstate_t state_reg;
    job_t    job_reg;
    rec_t    mem [SYMBOL_SLOTS];
    rec_t    rd_rec_reg;
    logic    rd_hit_reg;
    logic [SYMBOL_SLOTS-1:0] slot_valid_reg;
    logic    res_valid_reg;
    result_t res_reg;

    logic [ADDR_W-1:0] rd_addr, wr_addr;
    rec_t    cur, upd;
    logic [31:0] hl, hc, cl, m1, tr;
    logic    out_free, finish, wr_en;

    assign rd_addr  = ADDR_W'(pop_job.sym);
    assign wr_addr  = ADDR_W'(job_reg.sym);
    assign out_free = !res_valid_reg || result_ready;
    assign pop      = (state_reg == B_IDLE) && pop_valid;
    assign finish   = (state_reg == B_CALC) && out_free;
    assign wr_en    = finish && !job_reg.pass;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // never-written slots read as zero
    assign cur = rd_hit_reg ? rd_rec_reg : '0;

    // update the bar record
    always_comb
    begin
        upd = cur;
        if (cur.bar == job_reg.bar)
        begin
            if ($signed(job_reg.price) > $signed(cur.high))
                upd.high = job_reg.price;
            if ($signed(cur.low) > $signed(job_reg.price))
                upd.low = job_reg.price;
            upd.close = job_reg.price;
        end
        else
        begin
            upd.prev  = cur.close;
            upd.close = job_reg.price;
            upd.high  = job_reg.price;
            upd.low   = job_reg.price;
            upd.bar   = job_reg.bar;
        end
    end

    // true range with wrapped differences, signed maxima
    assign hl = upd.high - upd.low;
    assign hc = upd.high - upd.prev;
    assign cl = upd.prev - upd.low;
    assign m1 = ($signed(hl) > $signed(hc)) ? hl : hc;
    assign tr = ($signed(m1) > $signed(cl)) ? m1 : cl;

    // read the record of the popped word
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_rec_reg <= mem[rd_addr];
            rd_hit_reg <= slot_valid_reg[rd_addr];
            job_reg    <= pop_job;
        end
        if (wr_en)
            mem[wr_addr] <= upd;
    end

    // mark written slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_valid_reg <= '0;
        else if (wr_en)
            slot_valid_reg[wr_addr] <= 1'b1;
    end

    // sequence and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish)
                res_valid_reg <= job_reg.pass || (upd.prev != '0);
            else if (result_ready)
                res_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (pop_valid)
                        state_reg <= B_CALC;
                end
                B_CALC:
                begin
                    if (out_free)
                        state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    // load the output word
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            res_reg.result_symbol    <= job_reg.sym;
            res_reg.result_timestamp <= job_reg.ts;
            if (job_reg.pass)
            begin
                res_reg.result_kind  <= KIND_PASS;
                res_reg.result_value <= job_reg.price;
            end
            else
            begin
                res_reg.result_kind  <= KIND_TRUE_RANGE;
                res_reg.result_value <= tr;
            end
        end
    end

endmodule

FILE: rtl/core/per_symbol_true_range.sv
// Top level of the per-symbol true range block: registers, front, queue, back.
// Depends on psr_pkg, psr_front, psr_queue and psr_back.
//
//   channel  | signals                        | moves
//   ---------+--------------------------------+---------------------------
//   trade    | trade_valid/trade_ready, trade | one trade word in
//   result   | result_valid/result_ready      | one result word out
//   config   | cfg_write, cfg_index, cfg_data | register write, no wait
//
// A computed trade passes the front as accept, 63 divider steps of the
// one-bit-per-cycle bar divider, and push; the back handles each word as
// record read, then update and write. Pass-through trades skip the divider
// and go from accept straight to push. Reset clears all control state and
// marks every symbol record empty at once. A stalled result holds the back,
// and the queue lets the front keep dividing meanwhile until it fills.
module per_symbol_true_range
    import psr_pkg::*;
#(
    parameter int SYMBOL_SLOTS = DEFAULT_SYMBOL_SLOTS
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   trade_valid,
    output logic                   trade_ready,
    input  trade_t                 trade,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [31:0] interval_length_reg;
    logic [62:0] start_time_reg;
    logic        enabled_reg;

    logic push_valid, push_ready, pop_valid, pop;
    job_t push_job, pop_job;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_length_reg <= 32'd1;
            start_time_reg      <= '0;
            enabled_reg         <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_INTERVAL_LENGTH: interval_length_reg <= cfg_data[31:0];
                CFG_START_TIME:      start_time_reg      <= cfg_data;
                CFG_ENABLED:         enabled_reg         <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    psr_front #(.SYMBOL_SLOTS(SYMBOL_SLOTS)) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .trade_valid     (trade_valid),
        .trade_ready     (trade_ready),
        .trade           (trade),
        .interval_length (interval_length_reg),
        .start_time      (start_time_reg),
        .enabled         (enabled_reg),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_job        (push_job)
    );

    psr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_job    (pop_job)
    );

    psr_back #(.SYMBOL_SLOTS(SYMBOL_SLOTS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop          (pop),
        .pop_job      (pop_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: rtl/core/psr_checker.sv
// Port-level checks for the per-symbol true range block, bound to the top.
// Depends on psr_pkg and per_symbol_true_range.
module psr_checker
    import psr_pkg::*;
#(
    parameter int SYMBOL_SLOTS = DEFAULT_SYMBOL_SLOTS
)(
    input logic    clk,
    input logic    rst_n,
    input logic    trade_valid,
    input logic    trade_ready,
    input trade_t  trade,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // hold a stalled result word
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result word changed while stalled");

    // front goes busy after taking an in-range trade
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        trade_valid && trade_ready && (17'(trade.symbol_index) < 17'(SYMBOL_SLOTS))
        |=> !trade_ready)
        else $error("front accepted back to back");

    // no result during reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result valid during reset");

endmodule

bind per_symbol_true_range psr_checker #(.SYMBOL_SLOTS(SYMBOL_SLOTS)) u_psr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .trade_valid  (trade_valid),
    .trade_ready  (trade_ready),
    .trade        (trade),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
